>>> src/carp_parent_selector_defines.svh
// Assertion macros used by the checker of the peer selector.
// Both expect signals named clk and rst_n in the scope of use.
`ifndef CARP_PARENT_SELECTOR_DEFINES_SVH
`define CARP_PARENT_SELECTOR_DEFINES_SVH

// Same-cycle implication.
`define CARP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("carp_parent_selector: same-cycle check failed");

// Next-cycle implication.
`define CARP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("carp_parent_selector: next-cycle check failed");

`endif

>>> src/carp_pkg.sv
package carp_pkg;

    localparam int unsigned PEER_IDX_W = 5;

    // c + c * 0x62531965 folds into one multiply by the constant plus one
    localparam logic [31:0] MIX_MUL_PLUS1 = 32'h6253_1966;

    typedef struct packed {
        logic [7:0]            key_byte;
        logic                  key_last;
        logic                  peer_last;
        logic [PEER_IDX_W-1:0] peer_index;
        logic [31:0]           peer_hash;
        logic [31:0]           peer_load;
        logic                  peer_eligible;
    } key_item_t;

    typedef struct packed {
        logic [PEER_IDX_W-1:0] selected_peer;
        logic                  found;
    } sel_item_t;

    // controller to datapath
    typedef struct packed {
        logic accept;   // take one key item
        logic mix;      // hash mix multiply
        logic score;    // load multiply
        logic cmp;      // best-score compare
        logic publish;  // load the result register, clear request state
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic peer_last;
    } dp_status_t;

    // rotate left by 19 (byte hash)
    function automatic logic [31:0] rotl_byte(input logic [31:0] v);
        return {v[12:0], v[31:13]};
    endfunction

    // rotate left by 21 (final mix)
    function automatic logic [31:0] rotl_mix(input logic [31:0] v);
        return {v[10:0], v[31:11]};
    endfunction

endpackage

>>> src/carp_ctrl.sv
module carp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                key_valid,
    input  logic                key_last,
    output logic                key_stall,
    output logic                sel_valid,
    input  logic                sel_stall,
    output carp_pkg::dp_cmd_t   cmd,
    input  carp_pkg::dp_status_t status
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_MIX   = 5'b00010,
        ST_SCORE = 5'b00100,
        ST_CMP   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   sel_valid_reg, sel_valid_next;
    logic   out_free;

    assign key_stall = (state_reg != ST_IDLE);
    assign sel_valid = sel_valid_reg;
    assign out_free  = !sel_valid_reg || !sel_stall;

    always_comb
    begin
        state_next     = state_reg;
        sel_valid_next = sel_valid_reg && sel_stall;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (key_valid)
                begin
                    cmd.accept = 1'b1;
                    if (key_last)
                    begin
                        state_next = ST_MIX;
                    end
                end
            end
            ST_MIX:
            begin
                cmd.mix    = 1'b1;
                state_next = ST_SCORE;
            end
            ST_SCORE:
            begin
                cmd.score  = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = status.peer_last ? ST_DONE : ST_IDLE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.publish    = 1'b1;
                    sel_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_valid_reg <= sel_valid_next;
        end
    end

endmodule

>>> src/carp_dp.sv
module carp_dp #(
    parameter int unsigned PEER_COUNT = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  carp_pkg::key_item_t   key_item,
    input  carp_pkg::dp_cmd_t     cmd,
    output carp_pkg::dp_status_t  status,
    output carp_pkg::sel_item_t   sel_item
);

    logic [31:0] hash_reg, hash_next, hash_upd;
    logic [31:0] c0_reg, c1_reg, load_reg;
    logic [63:0] score_reg, score_next;
    logic [carp_pkg::PEER_IDX_W-1:0] index_reg, best_peer_reg;
    logic        elig_reg, peer_last_reg;
    logic [63:0] best_score_reg;
    logic        have_best_reg;
    logic        idx_ok, take;
    carp_pkg::sel_item_t result_reg;

    assign hash_upd = hash_reg + carp_pkg::rotl_byte(hash_reg) + {24'd0, key_item.key_byte};

    // the hash restarts at the end of a request; the mix input is taken first
    always_comb
    begin
        hash_next = hash_reg;
        if (cmd.accept)
        begin
            hash_next = (key_item.key_last && key_item.peer_last) ? 32'd0 : hash_upd;
        end
    end

    assign score_next = carp_pkg::rotl_mix(c1_reg) * load_reg;
    assign idx_ok     = (32'(index_reg) < PEER_COUNT);
    assign take       = elig_reg && idx_ok && (score_reg > best_score_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg       <= '0;
            best_score_reg <= '0;
            best_peer_reg  <= '0;
            have_best_reg  <= 1'b0;
        end
        else
        begin
            hash_reg <= hash_next;
            if (cmd.cmp && take)
            begin
                best_score_reg <= score_reg;
                best_peer_reg  <= index_reg;
                have_best_reg  <= 1'b1;
            end
            else if (cmd.publish)
            begin
                best_score_reg <= '0;
                have_best_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && key_item.key_last)
        begin
            c0_reg        <= hash_upd ^ key_item.peer_hash;
            load_reg      <= key_item.peer_load;
            index_reg     <= key_item.peer_index;
            elig_reg      <= key_item.peer_eligible;
            peer_last_reg <= key_item.peer_last;
        end
        if (cmd.mix)
        begin
            c1_reg <= c0_reg * carp_pkg::MIX_MUL_PLUS1;
        end
        if (cmd.score)
        begin
            score_reg <= score_next;
        end
        if (cmd.publish)
        begin
            result_reg.found         <= have_best_reg;
            result_reg.selected_peer <= have_best_reg ? best_peer_reg : '0;
        end
    end

    assign status.peer_last = peer_last_reg;
    assign sel_item         = result_reg;

endmodule

>>> src/carp_parent_selector.sv
// A key byte item without key_last is accepted without stalling the input. A key_last
// item passes through accept, mix multiply, load multiply and compare before the next
// item is taken; one that closes a request also passes publish first.
// sel_valid rises once the request-closing item has gone through these steps, later only
// while the previous result still sits unclaimed. rst_n (async, active low) clears
// the hash, best score, best peer and control state; no result is pending after reset.

// Structure: carp_ctrl sequences the multi-cycle key-end work, carp_dp
// holds the running hash, the two multiply stages and the best tracker.
// The running hash is shared across the peers of one request and restarts
// with the next request. Each multiply has a register behind it: the mix
// (32-bit constant product, low half) and the exact 64-bit load product.
// The result register lets a new request start streaming while the old
// result waits on sel_stall.
module carp_parent_selector #(
    parameter int unsigned PEER_COUNT = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                key_valid,
    output logic                key_stall,
    input  carp_pkg::key_item_t key_item,
    output logic                sel_valid,
    input  logic                sel_stall,
    output carp_pkg::sel_item_t sel_item
);

    carp_pkg::dp_cmd_t    cmd;
    carp_pkg::dp_status_t status;

    // sequencing: item acceptance, multiply steps, result publication
    carp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_valid (key_valid),
        .key_last  (key_item.key_last),
        .key_stall (key_stall),
        .sel_valid (sel_valid),
        .sel_stall (sel_stall),
        .cmd       (cmd),
        .status    (status)
    );

    // hash, score and best-peer tracking
    carp_dp #(
        .PEER_COUNT (PEER_COUNT)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .key_item (key_item),
        .cmd      (cmd),
        .status   (status),
        .sel_item (sel_item)
    );

endmodule

>>> src/carp_sva_checker.sv
`include "carp_parent_selector_defines.svh"

module carp_sva_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                key_valid,
    input logic                key_stall,
    input carp_pkg::key_item_t key_item,
    input logic                sel_valid,
    input logic                sel_stall,
    input carp_pkg::sel_item_t sel_item
);

    // a stalled result stays offered
    `CARP_ASSERT_NEXT(a_sel_hold, sel_valid && sel_stall, sel_valid)

    // when nothing was found the index reads zero
    `CARP_ASSERT_NOW(a_none_zero, sel_valid && !sel_item.found, sel_item.selected_peer == '0)

    // a plain key byte leaves the block ready for the next one
    `CARP_ASSERT_NEXT(a_byte_rate, key_valid && !key_stall && !key_item.key_last, !key_stall)

    // a key end occupies the mix multiply on the following cycle, stalling the input
    `CARP_ASSERT_NEXT(a_keyend_busy, key_valid && !key_stall && key_item.key_last, key_stall)

endmodule

bind carp_parent_selector carp_sva_checker u_sva_checker (.*);
